// ----- rtl/core/quaternion_arithmetic_unit_assert.svh -----
// assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// checked outside reset
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define QAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/qau_pkg.sv -----
`default_nettype none
package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int SQ_W      = 2*W + 1;
  localparam int RT_W      = W + 1;
  localparam int T_W       = 2*W + 2;
  localparam int PROD_W    = 2*W;
  localparam int SUM_W     = 2*W + 3;
  localparam int NUM_W     = 2*FRAC_BITS + W;
  localparam int DIV_W     = (NUM_W > SQ_W + W + 1) ? NUM_W : SQ_W + W + 1;

  localparam logic [3:0] K_ADD    = 4'd0;
  localparam logic [3:0] K_SUB    = 4'd1;
  localparam logic [3:0] K_MUL    = 4'd2;
  localparam logic [3:0] K_SCALE  = 4'd3;
  localparam logic [3:0] K_CONJ   = 4'd4;
  localparam logic [3:0] K_NORM   = 4'd5;
  localparam logic [3:0] K_RECIP  = 4'd6;
  localparam logic [3:0] K_VERSOR = 4'd7;
  localparam logic [3:0] K_LQUOT  = 4'd8;
  localparam logic [3:0] K_RQUOT  = 4'd9;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // hamilton product: term t of part c is p[t] * q[c ^ t], subtracted where set
  localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

  typedef logic [W-1:0] word_t;
  typedef word_t [3:0] quat_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [W-1:0] a_s;
    logic signed [W-1:0] a_i;
    logic signed [W-1:0] a_j;
    logic signed [W-1:0] a_k;
    logic signed [W-1:0] b_s;
    logic signed [W-1:0] b_i;
    logic signed [W-1:0] b_j;
    logic signed [W-1:0] b_k;
    logic signed [W-1:0] scale;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] x_s;
    logic signed [W-1:0] x_i;
    logic signed [W-1:0] x_j;
    logic signed [W-1:0] x_k;
    logic [1:0]          status;
  } out_t;

  typedef struct packed {
    logic [3:0] kind;
    quat_t      a;
    quat_t      b;
    word_t      sc;
    quat_t      ex;
    logic       esat;
  } ctx_t;

  function automatic logic [W:0] sat_narrow(input logic [W:0] v);
    if (v[W] != v[W-1]) begin
      return {1'b1, v[W], {(W-1){~v[W]}}};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] pack_sat(input logic neg, input logic [SUM_W-1:0] mag);
    logic [SUM_W-1:0] lim;
    logic [W-1:0]     v;
    lim = neg ? SUM_W'(64'h8000_0000) : SUM_W'(64'h7FFF_FFFF);
    v   = mag[W-1:0];
    if (mag > lim) begin
      return {1'b1, neg, {(W-1){~neg}}};
    end
    return {1'b0, neg ? -v : v};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qau_front.sv -----
`default_nettype none
module qau_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  qau_pkg::in_t                in_req,
  output logic                        v_out,
  output qau_pkg::ctx_t               ctx_out,
  output logic [qau_pkg::SQ_W-1:0]    s_out
);

  qau_pkg::ctx_t ctx_in;
  qau_pkg::ctx_t ctx1;
  qau_pkg::ctx_t ctx2;
  logic          v1;
  logic          v2;
  logic [qau_pkg::W:0] e [4];
  logic [qau_pkg::W:0] ea [4];
  logic [qau_pkg::W:0] eb [4];
  qau_pkg::quat_t sq_op;
  logic signed [qau_pkg::PROD_W-1:0] sq_next [4];
  logic [qau_pkg::PROD_W-1:0] sq [4];
  logic [qau_pkg::SQ_W-1:0] s_next;

  // early add, subtract and conjugate
  always_comb begin
    ctx_in.kind = in_req.kind;
    ctx_in.a    = {in_req.a_k, in_req.a_j, in_req.a_i, in_req.a_s};
    ctx_in.b    = {in_req.b_k, in_req.b_j, in_req.b_i, in_req.b_s};
    ctx_in.sc   = in_req.scale;
    for (int c = 0; c < 4; c++) begin
      ea[c] = {ctx_in.a[c][qau_pkg::W-1], ctx_in.a[c]};
      eb[c] = {ctx_in.b[c][qau_pkg::W-1], ctx_in.b[c]};
      case (in_req.kind)
        qau_pkg::K_ADD:  e[c] = qau_pkg::sat_narrow(ea[c] + eb[c]);
        qau_pkg::K_SUB:  e[c] = qau_pkg::sat_narrow(ea[c] - eb[c]);
        qau_pkg::K_CONJ: e[c] = (c == 0) ? {1'b0, ctx_in.a[c]} : qau_pkg::sat_narrow(-ea[c]);
        default:         e[c] = '0;
      endcase
      ctx_in.ex[c] = e[c][qau_pkg::W-1:0];
    end
    ctx_in.esat = e[0][qau_pkg::W] | e[1][qau_pkg::W] | e[2][qau_pkg::W] | e[3][qau_pkg::W];
  end

  always_comb begin
    if (ctx1.kind == qau_pkg::K_LQUOT || ctx1.kind == qau_pkg::K_RQUOT) begin
      sq_op = ctx1.b;
    end else begin
      sq_op = ctx1.a;
    end
    for (int c = 0; c < 4; c++) begin
      sq_next[c] = $signed(sq_op[c]) * $signed(sq_op[c]);
    end
  end

  assign s_next = {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]} + {1'b0, sq[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1    <= ctx_in;
      ctx2    <= ctx1;
      ctx_out <= ctx2;
      for (int c = 0; c < 4; c++) begin
        sq[c] <= sq_next[c];
      end
      s_out <= s_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qau_sqrt.sv -----
`default_nettype none
module qau_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        v_in,
  input  qau_pkg::ctx_t               ctx_in,
  input  logic [qau_pkg::SQ_W-1:0]    s_in,
  output logic                        v_out,
  output qau_pkg::ctx_t               ctx_out,
  output logic [qau_pkg::SQ_W-1:0]    s_out,
  output logic [qau_pkg::RT_W-1:0]    root_out
);

  logic                        vs  [qau_pkg::W];
  qau_pkg::ctx_t               cs  [qau_pkg::W];
  logic [qau_pkg::SQ_W-1:0]    ss  [qau_pkg::W];
  logic [qau_pkg::W-1:0]       rts [qau_pkg::W];
  logic [2*qau_pkg::W-1:0]     rms [qau_pkg::W];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < qau_pkg::W; k++) begin : g_step
    localparam int I = qau_pkg::W - 1 - k;
    logic                    v_p;
    qau_pkg::ctx_t           c_p;
    logic [qau_pkg::SQ_W-1:0] s_p;
    logic [qau_pkg::W-1:0]   rt_p;
    logic [2*qau_pkg::W-1:0] rm_p;
    logic [qau_pkg::T_W-1:0] t;
    logic                    fit;

    if (k == 0) begin : g_first
      assign v_p  = v_in;
      assign c_p  = ctx_in;
      assign s_p  = s_in;
      assign rt_p = '0;
      assign rm_p = s_in[2*qau_pkg::W-1:0];
    end else begin : g_rest
      assign v_p  = vs[k-1];
      assign c_p  = cs[k-1];
      assign s_p  = ss[k-1];
      assign rt_p = rts[k-1];
      assign rm_p = rms[k-1];
    end

    assign t = ({{(qau_pkg::T_W-qau_pkg::W){1'b0}}, rt_p} << (I + 1))
             + ({{(qau_pkg::T_W-1){1'b0}}, 1'b1} << (2*I));
    assign fit = {2'b00, rm_p} >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k]  <= c_p;
        ss[k]  <= s_p;
        rts[k] <= fit ? (rt_p | ({{(qau_pkg::W-1){1'b0}}, 1'b1} << I)) : rt_p;
        rms[k] <= fit ? (rm_p - t[2*qau_pkg::W-1:0]) : rm_p;
      end
    end
  end

  assign v_out    = vs[qau_pkg::W-1];
  assign ctx_out  = cs[qau_pkg::W-1];
  assign s_out    = ss[qau_pkg::W-1];
  assign root_out = ss[qau_pkg::W-1][qau_pkg::SQ_W-1] ? {1'b1, {qau_pkg::W{1'b0}}}
                                                       : {1'b0, rts[qau_pkg::W-1]};

endmodule
`default_nettype wire

// ----- rtl/core/qau_div.sv -----
`default_nettype none
module qau_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        v_in,
  input  qau_pkg::ctx_t               ctx_in,
  input  logic [qau_pkg::SQ_W-1:0]    s_in,
  input  logic [qau_pkg::RT_W-1:0]    n_in,
  output logic                        v_out,
  output qau_pkg::ctx_t               ctx_out,
  output qau_pkg::quat_t              r_out,
  output logic                        rsat_out,
  output logic                        dz_out
);

  qau_pkg::ctx_t               ctx_set;
  logic                        is_v;
  qau_pkg::word_t              op   [4];
  qau_pkg::word_t              mag  [4];
  logic [qau_pkg::NUM_W-1:0]   num  [4];
  logic [qau_pkg::SQ_W-1:0]    d_set;
  logic                        neg_set [4];
  logic                        ovf_set [4];

  logic                        v0;
  qau_pkg::ctx_t               c0;
  logic [qau_pkg::SQ_W-1:0]    d0;
  logic                        dz0;
  logic [qau_pkg::DIV_W-1:0]   rm0  [4];
  logic                        ng0  [4];
  logic                        ov0  [4];

  logic                        vs   [qau_pkg::W];
  qau_pkg::ctx_t               cs   [qau_pkg::W];
  logic [qau_pkg::SQ_W-1:0]    ds   [qau_pkg::W];
  logic                        dzs  [qau_pkg::W];
  logic [qau_pkg::DIV_W-1:0]   rms  [qau_pkg::W][4];
  logic [qau_pkg::W-1:0]       qs   [qau_pkg::W][4];
  logic                        ngs  [qau_pkg::W][4];
  logic                        ovs  [qau_pkg::W][4];

  logic [qau_pkg::W:0]         pk   [4];

  // operand setup, norm result and quotient overflow check
  always_comb begin
    ctx_set = ctx_in;
    is_v    = ctx_in.kind == qau_pkg::K_VERSOR;
    d_set   = is_v ? {{(qau_pkg::SQ_W-qau_pkg::RT_W){1'b0}}, n_in} : s_in;
    for (int c = 0; c < 4; c++) begin
      if (ctx_in.kind == qau_pkg::K_LQUOT || ctx_in.kind == qau_pkg::K_RQUOT) begin
        op[c] = ctx_in.b[c];
      end else begin
        op[c] = ctx_in.a[c];
      end
      mag[c] = op[c][qau_pkg::W-1] ? -op[c] : op[c];
      if (is_v || c == 0) begin
        neg_set[c] = op[c][qau_pkg::W-1];
      end else begin
        neg_set[c] = !op[c][qau_pkg::W-1] && (op[c] != '0);
      end
      if (is_v) begin
        num[c] = {{(qau_pkg::NUM_W-qau_pkg::W){1'b0}}, mag[c]} << qau_pkg::FRAC_BITS;
      end else begin
        num[c] = {{(qau_pkg::NUM_W-qau_pkg::W){1'b0}}, mag[c]} << (2*qau_pkg::FRAC_BITS);
      end
      ovf_set[c] = {{(qau_pkg::DIV_W-qau_pkg::NUM_W){1'b0}}, num[c]}
                 >= ({{(qau_pkg::DIV_W-qau_pkg::SQ_W){1'b0}}, d_set} << qau_pkg::W);
    end
    if (ctx_in.kind == qau_pkg::K_NORM) begin
      ctx_set.esat = n_in[qau_pkg::W] | n_in[qau_pkg::W-1];
      ctx_set.ex   = {{(3*qau_pkg::W){1'b0}},
                      ctx_set.esat ? {1'b0, {(qau_pkg::W-1){1'b1}}} : n_in[qau_pkg::W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0  <= ctx_set;
      d0  <= d_set;
      dz0 <= s_in == '0;
      for (int c = 0; c < 4; c++) begin
        rm0[c] <= {{(qau_pkg::DIV_W-qau_pkg::NUM_W){1'b0}}, num[c]};
        ng0[c] <= neg_set[c];
        ov0[c] <= ovf_set[c];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < qau_pkg::W; k++) begin : g_step
    localparam int I = qau_pkg::W - 1 - k;
    logic                      v_p;
    qau_pkg::ctx_t             c_p;
    logic [qau_pkg::SQ_W-1:0]  d_p;
    logic                      dz_p;
    logic [qau_pkg::DIV_W-1:0] rm_p [4];
    logic [qau_pkg::W-1:0]     q_p  [4];
    logic                      ng_p [4];
    logic                      ov_p [4];
    logic [qau_pkg::DIV_W-1:0] dsh;

    if (k == 0) begin : g_first
      assign v_p  = v0;
      assign c_p  = c0;
      assign d_p  = d0;
      assign dz_p = dz0;
      for (genvar c = 0; c < 4; c++) begin : g_lane
        assign rm_p[c] = rm0[c];
        assign q_p[c]  = '0;
        assign ng_p[c] = ng0[c];
        assign ov_p[c] = ov0[c];
      end
    end else begin : g_rest
      assign v_p  = vs[k-1];
      assign c_p  = cs[k-1];
      assign d_p  = ds[k-1];
      assign dz_p = dzs[k-1];
      for (genvar c = 0; c < 4; c++) begin : g_lane
        assign rm_p[c] = rms[k-1][c];
        assign q_p[c]  = qs[k-1][c];
        assign ng_p[c] = ngs[k-1][c];
        assign ov_p[c] = ovs[k-1][c];
      end
    end

    assign dsh = {{(qau_pkg::DIV_W-qau_pkg::SQ_W){1'b0}}, d_p} << I;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k]  <= c_p;
        ds[k]  <= d_p;
        dzs[k] <= dz_p;
        for (int c = 0; c < 4; c++) begin
          ngs[k][c] <= ng_p[c];
          ovs[k][c] <= ov_p[c];
          if (rm_p[c] >= dsh) begin
            rms[k][c] <= rm_p[c] - dsh;
            qs[k][c]  <= q_p[c] | ({{(qau_pkg::W-1){1'b0}}, 1'b1} << I);
          end else begin
            rms[k][c] <= rm_p[c];
            qs[k][c]  <= q_p[c];
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (ovs[qau_pkg::W-1][c]) begin
        pk[c] = {1'b1, ngs[qau_pkg::W-1][c], {(qau_pkg::W-1){~ngs[qau_pkg::W-1][c]}}};
      end else begin
        pk[c] = qau_pkg::pack_sat(ngs[qau_pkg::W-1][c],
                  {{(qau_pkg::SUM_W-qau_pkg::W){1'b0}}, qs[qau_pkg::W-1][c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= vs[qau_pkg::W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_out  <= cs[qau_pkg::W-1];
      dz_out   <= dzs[qau_pkg::W-1];
      rsat_out <= pk[0][qau_pkg::W] | pk[1][qau_pkg::W] | pk[2][qau_pkg::W] | pk[3][qau_pkg::W];
      for (int c = 0; c < 4; c++) begin
        r_out[c] <= pk[c][qau_pkg::W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qau_ham.sv -----
`default_nettype none
module qau_ham (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  qau_pkg::ctx_t        ctx_in,
  input  qau_pkg::quat_t       r_in,
  input  logic                 rsat_in,
  input  logic                 dz_in,
  output logic                 out_valid,
  output qau_pkg::out_t        out_rsp
);

  qau_pkg::quat_t p;
  qau_pkg::quat_t q;
  logic signed [qau_pkg::PROD_W-1:0] prod_next [4][4];

  logic                  v1;
  qau_pkg::ctx_t         c1;
  qau_pkg::quat_t        r1;
  logic                  rsat1;
  logic                  dz1;
  logic [qau_pkg::PROD_W-1:0] prod [4][4];

  logic                  v2;
  qau_pkg::ctx_t         c2;
  qau_pkg::quat_t        r2;
  logic                  rsat2;
  logic                  dz2;
  logic [qau_pkg::SUM_W-1:0] sum_next [4];
  logic [qau_pkg::SUM_W-1:0] sum [4];
  logic [qau_pkg::SUM_W-1:0] term;

  logic [qau_pkg::SUM_W-1:0] mag [4];
  logic [qau_pkg::W:0]       hp  [4];
  qau_pkg::quat_t            hx;
  logic                      hsat;
  qau_pkg::quat_t            x;
  logic [1:0]                st;
  qau_pkg::out_t             rsp_next;

  always_comb begin
    p = ctx_in.a;
    q = ctx_in.b;
    case (ctx_in.kind)
      qau_pkg::K_LQUOT: begin
        p = r_in;
        q = ctx_in.a;
      end
      qau_pkg::K_RQUOT: begin
        p = ctx_in.a;
        q = r_in;
      end
      qau_pkg::K_SCALE: begin
        p = {{(3*qau_pkg::W){1'b0}}, ctx_in.sc};
        q = ctx_in.a;
      end
      default: ;
    endcase
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod_next[c][t] = $signed(p[t]) * $signed(q[c ^ t]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_next[c] = '0;
      for (int t = 0; t < 4; t++) begin
        term = {{(qau_pkg::SUM_W-qau_pkg::PROD_W){prod[c][t][qau_pkg::PROD_W-1]}}, prod[c][t]};
        sum_next[c] = qau_pkg::HAM_NEG[c][t] ? sum_next[c] - term : sum_next[c] + term;
      end
    end
  end

  // truncate toward zero, saturate, then pick the result for the operation
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = sum[c][qau_pkg::SUM_W-1] ? -sum[c] : sum[c];
      hp[c]  = qau_pkg::pack_sat(sum[c][qau_pkg::SUM_W-1], mag[c] >> qau_pkg::FRAC_BITS);
      hx[c]  = hp[c][qau_pkg::W-1:0];
    end
    hsat = hp[0][qau_pkg::W] | hp[1][qau_pkg::W] | hp[2][qau_pkg::W] | hp[3][qau_pkg::W];
    x  = '0;
    st = qau_pkg::ST_OK;
    case (c2.kind)
      qau_pkg::K_ADD, qau_pkg::K_SUB, qau_pkg::K_CONJ, qau_pkg::K_NORM: begin
        x  = c2.ex;
        st = c2.esat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::K_MUL, qau_pkg::K_SCALE: begin
        x  = hx;
        st = hsat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      qau_pkg::K_RECIP, qau_pkg::K_VERSOR: begin
        if (dz2) begin
          st = qau_pkg::ST_DZ;
        end else begin
          x  = r2;
          st = rsat2 ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
      end
      qau_pkg::K_LQUOT, qau_pkg::K_RQUOT: begin
        if (dz2) begin
          st = qau_pkg::ST_DZ;
        end else begin
          x  = hx;
          st = (rsat2 | hsat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    rsp_next.x_s    = x[0];
    rsp_next.x_i    = x[1];
    rsp_next.x_j    = x[2];
    rsp_next.x_k    = x[3];
    rsp_next.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= v_in;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= ctx_in;
      r1    <= r_in;
      rsat1 <= rsat_in;
      dz1   <= dz_in;
      for (int c = 0; c < 4; c++) begin
        for (int t = 0; t < 4; t++) begin
          prod[c][t] <= prod_next[c][t];
        end
      end
      c2    <= c1;
      r2    <= r1;
      rsat2 <= rsat1;
      dz2   <= dz1;
      for (int c = 0; c < 4; c++) begin
        sum[c] <= sum_next[c];
      end
      out_rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/quaternion_arithmetic_unit.sv -----
// quaternion arithmetic unit, signed Q16.16 fixed point
// in channel: in_valid / in_ready with in_req, one request per accepted
//   cycle: operation kind, quaternions A and B and a real scale factor
// out channel: out_valid / out_ready with out_rsp, one result per request,
//   in request order: four result parts and a status (ok, saturated,
//   divide by zero)
// throughput: one request per cycle while the output is not stalled; every request
//   takes the same path
// depth: 72 register stages from the input to the output register, set by
//   the 32-stage square root and the 32-stage divider that produce one
//   result bit per stage
// stall: the whole pipeline advances as one; while the output register holds
//   a result that is not taken, in_ready is low and nothing moves
// reset: clears all valid bits only; the data registers are not reset
`default_nettype none
module quaternion_arithmetic_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qau_pkg::in_t   in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output qau_pkg::out_t  out_rsp
);

  logic                         en;
  logic                         f_v;
  qau_pkg::ctx_t                f_ctx;
  logic [qau_pkg::SQ_W-1:0]     f_s;
  logic                         r_v;
  qau_pkg::ctx_t                r_ctx;
  logic [qau_pkg::SQ_W-1:0]     r_s;
  logic [qau_pkg::RT_W-1:0]     r_root;
  logic                         d_v;
  qau_pkg::ctx_t                d_ctx;
  qau_pkg::quat_t               d_r;
  logic                         d_rsat;
  logic                         d_dz;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid && in_ready),
    .in_req   (in_req),
    .v_out    (f_v),
    .ctx_out  (f_ctx),
    .s_out    (f_s)
  );

  qau_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (f_v),
    .ctx_in   (f_ctx),
    .s_in     (f_s),
    .v_out    (r_v),
    .ctx_out  (r_ctx),
    .s_out    (r_s),
    .root_out (r_root)
  );

  qau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (r_v),
    .ctx_in   (r_ctx),
    .s_in     (r_s),
    .n_in     (r_root),
    .v_out    (d_v),
    .ctx_out  (d_ctx),
    .r_out    (d_r),
    .rsat_out (d_rsat),
    .dz_out   (d_dz)
  );

  qau_ham u_ham (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_in      (d_v),
    .ctx_in    (d_ctx),
    .r_in      (d_r),
    .rsat_in   (d_rsat),
    .dz_in     (d_dz),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

// ----- rtl/core/qau_checker.sv -----
`default_nettype none
`include "quaternion_arithmetic_unit_assert.svh"
module qau_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input qau_pkg::out_t out_rsp
);

  `QAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rsp),
              "result changed while stalled")
  `QAU_ASSERT(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")
  `QAU_ASSERT(a_dz_zero, out_valid && out_rsp.status == qau_pkg::ST_DZ |->
              out_rsp.x_s == 0 && out_rsp.x_i == 0 && out_rsp.x_j == 0 && out_rsp.x_k == 0,
              "divide by zero result not zero")
  `QAU_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind quaternion_arithmetic_unit qau_checker u_chk (.*);
`default_nettype wire

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = qau_pkg::FRAC_BITS;
  localparam int IDLE_LIMIT = 20000;

  // quaternion math on signed wide values
  typedef logic signed [127:0] wide_t;

  class quat_scoreboard;
    qau_pkg::out_t pending[$];
    int errors;

    function automatic logic signed [31:0] clamp(input wide_t v, inout bit sat);
      if (v > 128'sd2147483647) begin
        sat = 1;
        return 32'h7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    // truncate toward zero by FB fraction bits
    function automatic wide_t drop_frac(input wide_t v);
      wide_t m;
      m = v < 0 ? -v : v;
      m = m >> FB;
      return v < 0 ? -m : m;
    endfunction

    function automatic wide_t root_of(input wide_t v);
      logic [127:0] res, rem, bitv;
      res = 0;
      rem = v;
      bitv = 128'd1 << 126;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic void hamilton(input wide_t p[4], input wide_t q[4],
                                     output wide_t x[4], inout bit sat);
      wide_t s[4];
      s[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
      s[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
      s[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
      s[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
      for (int c = 0; c < 4; c++) x[c] = clamp(drop_frac(s[c]), sat);
    endfunction

    function automatic bit inverse(input wide_t q[4], output wide_t x[4], inout bit sat);
      wide_t s, v, m;
      s = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
      if (s == 0) begin
        for (int c = 0; c < 4; c++) x[c] = 0;
        return 1;
      end
      for (int c = 0; c < 4; c++) begin
        v = c == 0 ? q[0] : -q[c];
        m = v < 0 ? -v : v;
        m = (m << (2*FB)) / s;
        x[c] = clamp(v < 0 ? -m : m, sat);
      end
      return 0;
    endfunction

    function automatic qau_pkg::out_t compute(input qau_pkg::in_t r);
      wide_t a[4], b[4], x[4], inv[4], sc, n, m;
      bit sat, dz;
      qau_pkg::out_t o;
      sat = 0;
      dz = 0;
      a = '{r.a_s, r.a_i, r.a_j, r.a_k};
      b = '{r.b_s, r.b_i, r.b_j, r.b_k};
      sc = r.scale;
      for (int c = 0; c < 4; c++) x[c] = 0;
      case (r.kind)
        qau_pkg::K_ADD: for (int c = 0; c < 4; c++) x[c] = clamp(a[c] + b[c], sat);
        qau_pkg::K_SUB: for (int c = 0; c < 4; c++) x[c] = clamp(a[c] - b[c], sat);
        qau_pkg::K_MUL: hamilton(a, b, x, sat);
        qau_pkg::K_SCALE:
          for (int c = 0; c < 4; c++) x[c] = clamp(drop_frac(sc*a[c]), sat);
        qau_pkg::K_CONJ:
          for (int c = 0; c < 4; c++) x[c] = clamp(c == 0 ? a[0] : -a[c], sat);
        qau_pkg::K_NORM: begin
          n = root_of(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
          x[0] = clamp(n, sat);
        end
        qau_pkg::K_RECIP: dz = inverse(a, x, sat);
        qau_pkg::K_VERSOR: begin
          n = root_of(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
          if (n == 0) dz = 1;
          else begin
            for (int c = 0; c < 4; c++) begin
              m = a[c] < 0 ? -a[c] : a[c];
              m = (m << FB) / n;
              x[c] = clamp(a[c] < 0 ? -m : m, sat);
            end
          end
        end
        qau_pkg::K_LQUOT, qau_pkg::K_RQUOT: begin
          dz = inverse(b, inv, sat);
          if (!dz) begin
            if (r.kind == qau_pkg::K_LQUOT) hamilton(inv, a, x, sat);
            else hamilton(a, inv, x, sat);
          end
        end
        default: ;
      endcase
      if (dz) for (int c = 0; c < 4; c++) x[c] = 0;
      o.x_s = x[0][31:0];
      o.x_i = x[1][31:0];
      o.x_j = x[2][31:0];
      o.x_k = x[3][31:0];
      o.status = dz ? qau_pkg::ST_DZ : (sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK);
      return o;
    endfunction

    function void note_request(input qau_pkg::in_t r);
      pending.push_back(compute(r));
    endfunction

    function void check_result(input qau_pkg::out_t got);
      qau_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x_s !== want.x_s) begin
        $display("%0t x_s expected %h actual %h", $time, want.x_s, got.x_s);
        errors++;
      end
      if (got.x_i !== want.x_i) begin
        $display("%0t x_i expected %h actual %h", $time, want.x_i, got.x_i);
        errors++;
      end
      if (got.x_j !== want.x_j) begin
        $display("%0t x_j expected %h actual %h", $time, want.x_j, got.x_j);
        errors++;
      end
      if (got.x_k !== want.x_k) begin
        $display("%0t x_k expected %h actual %h", $time, want.x_k, got.x_k);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  qau_pkg::in_t in_req = '0;
  logic out_valid;
  logic out_ready = 0;
  qau_pkg::out_t out_rsp;

  quat_scoreboard board = new();
  int idle_cycles = 0;
  bit feeding_done = 0;

  always #4 clk = ~clk;

  quaternion_arithmetic_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return 32'h0;
      5, 6: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      7: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic qau_pkg::in_t rand_request();
    qau_pkg::in_t r;
    r.kind = 4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9) : $urandom_range(10, 15));
    r.a_s = rand_word();
    r.a_i = rand_word();
    r.a_j = rand_word();
    r.a_k = rand_word();
    r.b_s = rand_word();
    r.b_i = rand_word();
    r.b_j = rand_word();
    r.b_k = rand_word();
    r.scale = rand_word();
    if ($urandom_range(0, 19) == 0) {r.b_s, r.b_i, r.b_j, r.b_k} = '0;
    if ($urandom_range(0, 19) == 0) {r.a_s, r.a_i, r.a_j, r.a_k} = '0;
    return r;
  endfunction

  task automatic send(input qau_pkg::in_t r);
    in_valid <= 1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic pause();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_uniform(input logic [3:0] k, input logic [31:0] v);
    qau_pkg::in_t r;
    r.kind = k;
    {r.a_s, r.a_i, r.a_j, r.a_k} = {4{v}};
    {r.b_s, r.b_i, r.b_j, r.b_k} = {4{v}};
    r.scale = v;
    send(r);
  endtask

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_rsp);
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      phase++;
      if (phase == 400) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end
      if (feeding_done || (phase % 97) < 30) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    qau_pkg::in_t r;
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // operation sweep over extreme and plain values
    for (int k = 0; k <= 9; k++) send_uniform(k[3:0], 32'h7FFF_FFFF);
    send_uniform(qau_pkg::K_MUL, 32'h8000_0000);
    send_uniform(qau_pkg::K_CONJ, 32'h8000_0000);
    send_uniform(qau_pkg::K_RECIP, 32'h0);
    send_uniform(qau_pkg::K_VERSOR, 32'h0);
    send_uniform(qau_pkg::K_LQUOT, 32'h0);
    send_uniform(qau_pkg::K_RQUOT, 32'h0);
    send_uniform(qau_pkg::K_NORM, 32'h8000_0000);
    send_uniform(qau_pkg::K_RECIP, 32'h0000_0001);
    send_uniform(qau_pkg::K_SCALE, 32'hFFFF_0000);
    send_uniform(4'd15, 32'h1234_5678);
    send_uniform(qau_pkg::K_RQUOT, 32'h0001_0000);
    pause();
    for (int n = 0; n < 1200; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        r = rand_request();
        send(r);
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause();
    end
    in_valid <= 0;
    feeding_done = 1;
    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
